@@ hdl/sccmwp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccmwp_pkg
// Shared sizes, command codes and memory word layouts for the condensed
// heaviest-path unit.
// ----------------------------------------------------------------------------
package sccmwp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int LINK_W    = EDGE_W + 1;
  localparam int COUNT_W   = NODE_W + 1;
  localparam int CASH_W    = 16;
  localparam int SUM_W     = 26;
  localparam int CMD_W     = 3;

  // Link value that ends an edge list
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_EDGES);

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CASH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MARK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RUN   = 3'd4;

  // Per-node load store
  typedef struct packed {
    logic [LINK_W-1:0] first;
    logic [CASH_W-1:0] cash;
    logic              mark;
  } node_word_t;

  // Edge store: destination and next link of the source's list
  typedef struct packed {
    logic [NODE_W-1:0] dest;
    logic [LINK_W-1:0] next;
  } edge_word_t;

  // Per-node search state of one run
  typedef struct packed {
    logic               visited;
    logic [COUNT_W-1:0] visit;
    logic               onstack;
    logic [NODE_W-1:0]  comp;
  } tarj_word_t;

  // Depth-first frame saved below the cached top
  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [LINK_W-1:0]  edge_ptr;
    logic [COUNT_W-1:0] low;
    logic [COUNT_W-1:0] visit;
  } frame_t;

  // Per-component cash and best path total
  typedef struct packed {
    logic [SUM_W-1:0] cash;
    logic [SUM_W-1:0] best;
    logic             valid;
  } comp_word_t;

endpackage

@@ hdl/sccmwp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sccmwp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sccmwp_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/scc_condensed_max_weight_path_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_condensed_max_weight_path_unit
// Loads edges, node cash and end marks, then on a run request groups the
// reachable nodes into strongly connected components and returns the
// heaviest cash path from the start component to a marked component.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid_i / in_stall_o | command_i node_a_i node_b_i amount_i
//  out     | out_valid_o/ out_stall_i| best_total_o found_o edges_dropped_o
//  cfg     | cfg_valid_i/ cfg_ready_o| node_count_i
//
// Edge, cash and mark requests read the node store, then write it back; an
// edge request is dropped and flagged once the edge store is full. Clear
// and reset sweep the node store with in_stall_o high. A run sweeps the
// search stores, then makes three passes over the visited nodes and edges,
// all on the single read port of each registered-read memory. A finished
// result waits in the output register; further requests, runs too, are taken.
// ----------------------------------------------------------------------------
module scc_condensed_max_weight_path_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sccmwp_pkg::CMD_W-1:0]          command_i,
  input  logic [sccmwp_pkg::NODE_W-1:0]         node_a_i,
  input  logic [sccmwp_pkg::NODE_W-1:0]         node_b_i,
  input  logic [sccmwp_pkg::CASH_W-1:0]         amount_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sccmwp_pkg::SUM_W-1:0]          best_total_o,
  output logic                                  found_o,
  output logic                                  edges_dropped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sccmwp_pkg::COUNT_W-1:0]        node_count_i
);

  localparam int NW = sccmwp_pkg::NODE_W;
  localparam int EW = sccmwp_pkg::EDGE_W;
  localparam int LW = sccmwp_pkg::LINK_W;
  localparam int CW = sccmwp_pkg::COUNT_W;
  localparam int SW = sccmwp_pkg::SUM_W;

  localparam logic [4:0] ST_CLEAR    = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_LOAD     = 5'd2;
  localparam logic [4:0] ST_RCLR     = 5'd3;
  localparam logic [4:0] ST_ENTER    = 5'd4;
  localparam logic [4:0] ST_STEP     = 5'd5;
  localparam logic [4:0] ST_EDGE     = 5'd6;
  localparam logic [4:0] ST_VISIT    = 5'd7;
  localparam logic [4:0] ST_CL_RD    = 5'd8;
  localparam logic [4:0] ST_CL_W     = 5'd9;
  localparam logic [4:0] ST_CL_C     = 5'd10;
  localparam logic [4:0] ST_RELOAD   = 5'd11;
  localparam logic [4:0] ST_RELOAD_D = 5'd12;
  localparam logic [4:0] ST_P_I0     = 5'd13;
  localparam logic [4:0] ST_P_I1     = 5'd14;
  localparam logic [4:0] ST_P_V      = 5'd15;
  localparam logic [4:0] ST_P_V1     = 5'd16;
  localparam logic [4:0] ST_P_V2     = 5'd17;
  localparam logic [4:0] ST_P_V3     = 5'd18;
  localparam logic [4:0] ST_P_E      = 5'd19;
  localparam logic [4:0] ST_P_E1     = 5'd20;
  localparam logic [4:0] ST_P_E2     = 5'd21;
  localparam logic [4:0] ST_P_E3     = 5'd22;
  localparam logic [4:0] ST_S_I      = 5'd23;
  localparam logic [4:0] ST_S_I1     = 5'd24;
  localparam logic [4:0] ST_S_I2     = 5'd25;
  localparam logic [4:0] ST_DONE     = 5'd26;

  // Registers
  logic [4:0]                    state_q, state_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [LW-1:0]                 et_q, et_d;
  logic                          ovf_q, ovf_d;
  logic [CW-1:0]                 ncount_q, ncount_d;
  logic [sccmwp_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [NW-1:0]                 a_q, a_d;
  logic [NW-1:0]                 b_q, b_d;
  logic [sccmwp_pkg::CASH_W-1:0] amt_q, amt_d;
  logic [CW-1:0]                 pd_q, pd_d;
  logic [CW-1:0]                 wd_q, wd_d;
  logic [CW-1:0]                 vc_q, vc_d;
  logic [CW-1:0]                 cc_q, cc_d;
  logic [CW-1:0]                 fc_q, fc_d;
  logic [NW-1:0]                 t_node_q, t_node_d;
  logic [LW-1:0]                 t_edge_q, t_edge_d;
  logic [CW-1:0]                 t_low_q, t_low_d;
  logic [CW-1:0]                 t_visit_q, t_visit_d;
  logic [NW-1:0]                 w_q, w_d;
  logic [SW-1:0]                 acc_q, acc_d;
  logic [NW-1:0]                 cur_c_q, cur_c_d;
  logic [SW-1:0]                 bc_q, bc_d;
  logic                          found_q, found_d;
  logic [SW-1:0]                 best_q, best_d;
  logic                          out_valid_q, out_valid_d;
  logic [SW-1:0]                 out_best_q, out_best_d;
  logic                          out_found_q, out_found_d;
  logic                          out_drop_q, out_drop_d;

  // Memory ports
  logic                   node_we;
  logic [NW-1:0]          node_waddr, node_raddr;
  sccmwp_pkg::node_word_t node_wdata, node_rd;
  logic                   edge_we;
  logic [EW-1:0]          edge_waddr, edge_raddr;
  sccmwp_pkg::edge_word_t edge_wdata, edge_rd;
  logic                   tarj_we;
  logic [NW-1:0]          tarj_waddr, tarj_raddr;
  sccmwp_pkg::tarj_word_t tarj_wdata, tarj_rd;
  logic                   pend_we;
  logic [NW-1:0]          pend_waddr, pend_raddr, pend_wdata, pend_rd;
  logic                   walk_we;
  logic [NW-1:0]          walk_waddr, walk_raddr;
  sccmwp_pkg::frame_t     walk_wdata, walk_rd;
  logic                   comp_we;
  logic [NW-1:0]          comp_waddr, comp_raddr;
  sccmwp_pkg::comp_word_t comp_wdata, comp_rd;
  logic                   fin_we;
  logic [NW-1:0]          fin_waddr, fin_raddr, fin_wdata, fin_rd;

  // Scratch values
  logic [CW-1:0]          n_lim;
  logic [CW-1:0]          vc_next;
  logic [SW-1:0]          sum;
  logic [SW-1:0]          cand;
  sccmwp_pkg::node_word_t nw_mod;

  assign n_lim = (ncount_q > CW'(sccmwp_pkg::MAX_NODES)) ?
                 CW'(sccmwp_pkg::MAX_NODES) : ncount_q;
  assign vc_next = vc_q + CW'(1);
  assign sum  = acc_q + SW'(node_rd.cash);
  assign cand = bc_q + comp_rd.cash;

  // Next-state and memory control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    et_d        = et_q;
    ovf_d       = ovf_q;
    ncount_d    = cfg_valid_i ? node_count_i : ncount_q;
    cmd_d       = cmd_q;
    a_d         = a_q;
    b_d         = b_q;
    amt_d       = amt_q;
    pd_d        = pd_q;
    wd_d        = wd_q;
    vc_d        = vc_q;
    cc_d        = cc_q;
    fc_d        = fc_q;
    t_node_d    = t_node_q;
    t_edge_d    = t_edge_q;
    t_low_d     = t_low_q;
    t_visit_d   = t_visit_q;
    w_d         = w_q;
    acc_d       = acc_q;
    cur_c_d     = cur_c_q;
    bc_d        = bc_q;
    found_d     = found_q;
    best_d      = best_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_best_d  = out_best_q;
    out_found_d = out_found_q;
    out_drop_d  = out_drop_q;

    node_we    = 1'b0;
    node_waddr = a_q;
    node_wdata = node_rd;
    node_raddr = a_q;
    edge_we    = 1'b0;
    edge_waddr = et_q[EW-1:0];
    edge_wdata = '{dest: b_q, next: node_rd.first};
    edge_raddr = t_edge_q[EW-1:0];
    tarj_we    = 1'b0;
    tarj_waddr = w_q;
    tarj_wdata = '0;
    tarj_raddr = w_q;
    pend_we    = 1'b0;
    pend_waddr = pd_q[NW-1:0];
    pend_wdata = w_q;
    pend_raddr = NW'(pd_q - CW'(1));
    walk_we    = 1'b0;
    walk_waddr = NW'(wd_q - CW'(1));
    walk_wdata = '{node: t_node_q, edge_ptr: t_edge_q, low: t_low_q, visit: t_visit_q};
    walk_raddr = NW'(wd_q - CW'(1));
    comp_we    = 1'b0;
    comp_waddr = w_q;
    comp_wdata = '0;
    comp_raddr = w_q;
    fin_we     = 1'b0;
    fin_waddr  = fc_q[NW-1:0];
    fin_wdata  = pend_rd;
    fin_raddr  = NW'(fc_q - CW'(1));
    nw_mod     = node_rd;

    case (state_q)
      // Sweep the node store to its empty contents
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = idx_q[NW-1:0];
        node_wdata = '{first: sccmwp_pkg::EMPTY_LINK, cash: '0, mark: 1'b0};
        idx_d      = idx_q + CW'(1);
        if (idx_q[NW-1:0] == {NW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end

      // Take a request
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          a_d        = node_a_i;
          b_d        = node_b_i;
          amt_d      = amount_i;
          node_raddr = node_a_i;
          case (command_i) inside
            sccmwp_pkg::CMD_CLEAR: begin
              idx_d   = '0;
              et_d    = '0;
              ovf_d   = 1'b0;
              state_d = ST_CLEAR;
            end
            sccmwp_pkg::CMD_EDGE: begin
              if (et_q[EW]) begin
                ovf_d = 1'b1;
              end else begin
                state_d = ST_LOAD;
              end
            end
            sccmwp_pkg::CMD_CASH, sccmwp_pkg::CMD_MARK: begin
              state_d = ST_LOAD;
            end
            sccmwp_pkg::CMD_RUN: begin
              idx_d   = '0;
              state_d = ST_RCLR;
            end
            default: begin
            end
          endcase
        end
      end

      // Write back the modified node word
      ST_LOAD: begin
        case (cmd_q)
          sccmwp_pkg::CMD_EDGE: begin
            edge_we      = 1'b1;
            nw_mod.first = et_q;
            et_d         = et_q + LW'(1);
          end
          sccmwp_pkg::CMD_CASH: nw_mod.cash = amt_q;
          sccmwp_pkg::CMD_MARK: nw_mod.mark = 1'b1;
          default: begin
          end
        endcase
        node_we    = 1'b1;
        node_wdata = nw_mod;
        state_d    = ST_IDLE;
      end

      // Clear search and component stores, then enter the start node if it is in range
      ST_RCLR: begin
        tarj_we    = 1'b1;
        tarj_waddr = idx_q[NW-1:0];
        comp_we    = 1'b1;
        comp_waddr = idx_q[NW-1:0];
        idx_d      = idx_q + CW'(1);
        if (idx_q[NW-1:0] == {NW{1'b1}}) begin
          pd_d    = '0;
          wd_d    = '0;
          vc_d    = '0;
          cc_d    = '0;
          fc_d    = '0;
          acc_d   = '0;
          found_d = 1'b0;
          best_d  = '0;
          w_d     = a_q;
          if ({1'b0, a_q} < n_lim) begin
            state_d = ST_ENTER;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // Number a new node and make it the top frame
      ST_ENTER: begin
        tarj_we    = 1'b1;
        tarj_wdata = '{visited: 1'b1, visit: vc_next, onstack: 1'b1, comp: '0};
        pend_we    = 1'b1;
        t_node_d   = w_q;
        t_edge_d   = node_rd.first;
        t_low_d    = vc_next;
        t_visit_d  = vc_next;
        pd_d       = pd_q + CW'(1);
        wd_d       = wd_q + CW'(1);
        vc_d       = vc_next;
        state_d    = ST_STEP;
      end

      // Follow the next edge of the top, or pop it
      ST_STEP: begin
        if (!t_edge_q[EW]) begin
          state_d = ST_EDGE;
        end else begin
          wd_d = wd_q - CW'(1);
          if (t_low_q == t_visit_q) begin
            state_d = ST_CL_RD;
          end else begin
            state_d = ST_RELOAD;
          end
        end
      end

      ST_EDGE: begin
        t_edge_d   = edge_rd.next;
        tarj_raddr = edge_rd.dest;
        w_d        = edge_rd.dest;
        if ({1'b0, edge_rd.dest} >= n_lim) begin
          state_d = ST_STEP;
        end else begin
          state_d = ST_VISIT;
        end
      end

      // Descend into a new node, or lower the top's low mark
      ST_VISIT: begin
        if (!tarj_rd.visited) begin
          walk_we    = 1'b1;
          node_raddr = w_q;
          state_d    = ST_ENTER;
        end else begin
          if (tarj_rd.onstack && (tarj_rd.visit < t_low_q)) begin
            t_low_d = tarj_rd.visit;
          end
          state_d = ST_STEP;
        end
      end

      // Pop members of a finished component
      ST_CL_RD: begin
        pd_d    = pd_q - CW'(1);
        state_d = ST_CL_W;
      end

      ST_CL_W: begin
        node_raddr = pend_rd;
        tarj_we    = 1'b1;
        tarj_waddr = pend_rd;
        tarj_wdata = '{visited: 1'b1, visit: '0, onstack: 1'b0, comp: cc_q[NW-1:0]};
        fin_we     = 1'b1;
        fc_d       = fc_q + CW'(1);
        w_d        = pend_rd;
        state_d    = ST_CL_C;
      end

      ST_CL_C: begin
        if ((w_q == t_node_q) || (pd_q == '0)) begin
          comp_we    = 1'b1;
          comp_waddr = cc_q[NW-1:0];
          comp_wdata = '{cash: sum, best: '0, valid: 1'b0};
          cc_d       = cc_q + CW'(1);
          acc_d      = '0;
          state_d    = ST_RELOAD;
        end else begin
          acc_d   = sum;
          state_d = ST_CL_RD;
        end
      end

      // Restore the parent frame and carry the low mark up, or start the path pass at the root
      ST_RELOAD: begin
        if (wd_q == '0) begin
          state_d = ST_P_I0;
        end else begin
          state_d = ST_RELOAD_D;
        end
      end

      ST_RELOAD_D: begin
        t_node_d  = walk_rd.node;
        t_edge_d  = walk_rd.edge_ptr;
        t_visit_d = walk_rd.visit;
        t_low_d   = (walk_rd.low < t_low_q) ? walk_rd.low : t_low_q;
        state_d   = ST_STEP;
      end

      // Seed the start component
      ST_P_I0: begin
        comp_raddr = NW'(cc_q - CW'(1));
        state_d    = ST_P_I1;
      end

      ST_P_I1: begin
        comp_we    = 1'b1;
        comp_waddr = NW'(cc_q - CW'(1));
        comp_wdata = '{cash: comp_rd.cash, best: comp_rd.cash, valid: 1'b1};
        state_d    = ST_P_V;
      end

      // Relax edges of nodes in topological order
      ST_P_V: begin
        if (fc_q == '0) begin
          idx_d   = '0;
          state_d = ST_S_I;
        end else begin
          fc_d    = fc_q - CW'(1);
          state_d = ST_P_V1;
        end
      end

      ST_P_V1: begin
        tarj_raddr = fin_rd;
        node_raddr = fin_rd;
        state_d    = ST_P_V2;
      end

      ST_P_V2: begin
        cur_c_d    = tarj_rd.comp;
        t_edge_d   = node_rd.first;
        comp_raddr = tarj_rd.comp;
        state_d    = ST_P_V3;
      end

      ST_P_V3: begin
        bc_d = comp_rd.best;
        if (comp_rd.valid) begin
          state_d = ST_P_E;
        end else begin
          state_d = ST_P_V;
        end
      end

      ST_P_E: begin
        if (t_edge_q[EW]) begin
          state_d = ST_P_V;
        end else begin
          state_d = ST_P_E1;
        end
      end

      ST_P_E1: begin
        t_edge_d   = edge_rd.next;
        tarj_raddr = edge_rd.dest;
        if ({1'b0, edge_rd.dest} >= n_lim) begin
          state_d = ST_P_E;
        end else begin
          state_d = ST_P_E2;
        end
      end

      ST_P_E2: begin
        comp_raddr = tarj_rd.comp;
        w_d        = tarj_rd.comp;
        if (tarj_rd.comp == cur_c_q) begin
          state_d = ST_P_E;
        end else begin
          state_d = ST_P_E3;
        end
      end

      ST_P_E3: begin
        if (!comp_rd.valid || (cand > comp_rd.best)) begin
          comp_we    = 1'b1;
          comp_wdata = '{cash: comp_rd.cash, best: cand, valid: 1'b1};
        end
        state_d = ST_P_E;
      end

      // Scan marked nodes for the best total
      ST_S_I: begin
        node_raddr = idx_q[NW-1:0];
        tarj_raddr = idx_q[NW-1:0];
        if (idx_q == n_lim) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_S_I1;
        end
      end

      ST_S_I1: begin
        idx_d      = idx_q + CW'(1);
        comp_raddr = tarj_rd.comp;
        if (node_rd.mark && tarj_rd.visited) begin
          state_d = ST_S_I2;
        end else begin
          state_d = ST_S_I;
        end
      end

      ST_S_I2: begin
        if (comp_rd.valid && (!found_q || (comp_rd.best > best_q))) begin
          best_d  = comp_rd.best;
          found_d = 1'b1;
        end
        state_d = ST_S_I;
      end

      // Hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_best_d  = found_q ? best_q : '0;
          out_found_d = found_q;
          out_drop_d  = ovf_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      et_q        <= '0;
      ovf_q       <= 1'b0;
      ncount_q    <= CW'(1);
      pd_q        <= '0;
      wd_q        <= '0;
      vc_q        <= '0;
      cc_q        <= '0;
      fc_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      et_q        <= et_d;
      ovf_q       <= ovf_d;
      ncount_q    <= ncount_d;
      pd_q        <= pd_d;
      wd_q        <= wd_d;
      vc_q        <= vc_d;
      cc_q        <= cc_d;
      fc_q        <= fc_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    a_q         <= a_d;
    b_q         <= b_d;
    amt_q       <= amt_d;
    t_node_q    <= t_node_d;
    t_edge_q    <= t_edge_d;
    t_low_q     <= t_low_d;
    t_visit_q   <= t_visit_d;
    w_q         <= w_d;
    acc_q       <= acc_d;
    cur_c_q     <= cur_c_d;
    bc_q        <= bc_d;
    best_q      <= best_d;
    out_best_q  <= out_best_d;
    out_found_q <= out_found_d;
    out_drop_q  <= out_drop_d;
  end

  // Memories
  sccmwp_ram #(.WIDTH($bits(sccmwp_pkg::node_word_t)), .DEPTH(sccmwp_pkg::MAX_NODES)) u_node (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rd)
  );
  sccmwp_ram #(.WIDTH($bits(sccmwp_pkg::edge_word_t)), .DEPTH(sccmwp_pkg::MAX_EDGES)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rd)
  );
  sccmwp_ram #(.WIDTH($bits(sccmwp_pkg::tarj_word_t)), .DEPTH(sccmwp_pkg::MAX_NODES)) u_tarj (
    .clk_i, .we_i(tarj_we), .waddr_i(tarj_waddr), .wdata_i(tarj_wdata),
    .raddr_i(tarj_raddr), .rdata_o(tarj_rd)
  );
  sccmwp_ram #(.WIDTH(NW), .DEPTH(sccmwp_pkg::MAX_NODES)) u_pend (
    .clk_i, .we_i(pend_we), .waddr_i(pend_waddr), .wdata_i(pend_wdata),
    .raddr_i(pend_raddr), .rdata_o(pend_rd)
  );
  sccmwp_ram #(.WIDTH($bits(sccmwp_pkg::frame_t)), .DEPTH(sccmwp_pkg::MAX_NODES)) u_walk (
    .clk_i, .we_i(walk_we), .waddr_i(walk_waddr), .wdata_i(walk_wdata),
    .raddr_i(walk_raddr), .rdata_o(walk_rd)
  );
  sccmwp_ram #(.WIDTH($bits(sccmwp_pkg::comp_word_t)), .DEPTH(sccmwp_pkg::MAX_NODES)) u_comp (
    .clk_i, .we_i(comp_we), .waddr_i(comp_waddr), .wdata_i(comp_wdata),
    .raddr_i(comp_raddr), .rdata_o(comp_rd)
  );
  sccmwp_ram #(.WIDTH(NW), .DEPTH(sccmwp_pkg::MAX_NODES)) u_fin (
    .clk_i, .we_i(fin_we), .waddr_i(fin_waddr), .wdata_i(fin_wdata),
    .raddr_i(fin_raddr), .rdata_o(fin_rd)
  );

  // Ports
  assign in_stall_o      = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign best_total_o    = out_best_q;
  assign found_o         = out_found_q;
  assign edges_dropped_o = out_drop_q;

  // Checks
  a_depths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wd_q <= pd_q) && (pd_q <= vc_q))
    else $error("walk depth exceeds pending depth or visit count");

  a_comps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q <= vc_q)
    else $error("more components than visited nodes");

  a_edge_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    et_q <= LW'(sccmwp_pkg::MAX_EDGES))
    else $error("edge count beyond capacity");

  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (best_total_o == '0))
    else $error("nonzero total without a reachable mark");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (command_i == sccmwp_pkg::CMD_RUN)) |=> in_stall_o)
    else $error("request taken right after a run request");

endmodule
